// ===== rtl/lsh_pkg.sv =====
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared constants and types for the 3x3 cross-kernel sharpening filter.
// ----------------------------------------------------------------------------
package lsh_pkg;

   // default geometry of the block
   localparam int LSH_MAX_WIDTH  = 2048;
   localparam int LSH_CHANNELS   = 3;

   // fixed field widths
   localparam int SAMPLE_W       = 8;
   localparam int FWIDTH_W       = 12;
   localparam int ROW_W          = 16;
   localparam int COUNT_W        = 32;
   localparam int PADDR_W        = 3;
   localparam int PDATA_W        = 32;

   // register reset values
   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;
   localparam int MIN_DIM          = 3;

   // kernel centre weight
   localparam int SHARP_GAIN     = 5;

   // depth of the result queue
   localparam int OUT_QDEPTH     = 4;

   // register select (paddr word index)
   localparam logic [PADDR_W-3:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [PADDR_W-3:0] REG_FRAME_HEIGHT = 1'b1;

   // one channel's neighbourhood, as handed to a lane
   typedef struct packed {
      logic [SAMPLE_W-1:0] centre;
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic [SAMPLE_W-1:0] up;
      logic [SAMPLE_W-1:0] down;
   } lane_taps_type;

endpackage

// ===== rtl/lsh_ram.sv =====
// ----------------------------------------------------------------------------
// lsh_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsh_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lsh_lane.sv =====
// ----------------------------------------------------------------------------
// lsh_lane
// One channel of the cross kernel: 5*centre minus four neighbours, clamped.
// ----------------------------------------------------------------------------
module lsh_lane import lsh_pkg::*; (
   input  lane_taps_type       taps,
   input  logic                interior,
   output logic [SAMPLE_W-1:0] sharp
);

   logic [SAMPLE_W+2:0] centre_x5;
   logic [SAMPLE_W+1:0] nb_sum;
   logic [SAMPLE_W+2:0] diff;

   always_comb begin
      centre_x5 = (SAMPLE_W+3)'(SHARP_GAIN) * {3'b000, taps.centre};
      nb_sum    = {2'b00, taps.left} + {2'b00, taps.right}
                + {2'b00, taps.up} + {2'b00, taps.down};
      diff      = centre_x5 - {1'b0, nb_sum};
      if (!interior || centre_x5 <= {1'b0, nb_sum}) begin
         sharp = '0;
      end else if (diff[SAMPLE_W+2:SAMPLE_W] != 3'b000) begin
         sharp = '1;
      end else begin
         sharp = diff[SAMPLE_W-1:0];
      end
   end

endmodule

// ===== rtl/lsh_outq.sv =====
// ----------------------------------------------------------------------------
// lsh_outq
// Small result queue between the filter pipeline and the output channel.
// ----------------------------------------------------------------------------
module lsh_outq #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head_data,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== rtl/laplacian_sharpen_3x3.sv =====
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3
// Streaming 3x3 cross-kernel sharpener for raster-order pixels. It takes one
// pixel per clock while req_stall is low. A taken pixel passes through the
// registered read of the two line-buffer RAMs, then through the kernel lanes
// into the result queue. Each pixel gives 5*centre minus its four cross
// neighbours per channel, clamped to 0..255, with 0 on the border rows and
// columns. Results trail the input by one row plus one pixel, so after the
// last pixel of a frame the host sends effective width+1 pad items to
// flush the remainder; the last result of the frame carries frame_end. The
// line buffers need no clearing after reset and a pad item arriving while
// frame pixels are still due is dropped. The effective width is frame_width
// clamped to 3..MAX_WIDTH, the effective height frame_height raised to at
// least 3.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3 import lsh_pkg::*; #(
   parameter int MAX_WIDTH = LSH_MAX_WIDTH,
   parameter int CHANNELS  = LSH_CHANNELS
) (
   input  logic                clock,
   input  logic                reset,
   // pixel input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample_a,
   input  logic [SAMPLE_W-1:0] req_sample_b,
   input  logic [SAMPLE_W-1:0] req_sample_c,
   input  logic                req_is_pad,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_sharp_a,
   output logic [SAMPLE_W-1:0] rsp_sharp_b,
   output logic [SAMPLE_W-1:0] rsp_sharp_c,
   output logic                rsp_frame_end,
   // register port
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [PADDR_W-1:0]  paddr,
   input  logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]  prdata,
   output logic                pready
);

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WE_W      = COL_W + 1;
   localparam int TOT_W     = WE_W + ROW_W;
   localparam int USED      = (CHANNELS < 3) ? CHANNELS : 3;
   localparam int PIX_W     = SAMPLE_W * USED;
   localparam int QW        = PIX_W + 1;
   localparam int QCNT_W    = $clog2(OUT_QDEPTH + 1);
   localparam int RST_WEFF  = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
   localparam int RST_TOTAL = RST_WEFF * FRAME_HEIGHT_RST;

   typedef struct packed {
      logic pix;        // frame pixel: touches line buffers and window
      logic emit;       // gives a result
      logic interior;   // kernel result rather than border zero
      logic frame_end;
   } s1_ctrl_type;

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   logic                   cfg_wr;
   logic [PADDR_W-3:0]     reg_sel;
   logic [FWIDTH_W-1:0]    frame_width_ff, frame_width_in;
   logic [ROW_W-1:0]       frame_height_ff, frame_height_in;
   logic [WE_W-1:0]        w_eff_ff, w_eff_in, w_new;
   logic [ROW_W-1:0]       h_eff_ff, h_eff_in, h_new;
   logic [TOT_W-1:0]       total_ff, total_in;

   assign cfg_wr  = psel && penable && pwrite;
   assign reg_sel = paddr[PADDR_W-1:2];
   assign pready  = 1'b1;

   always_comb begin
      if (pwdata[FWIDTH_W-1:0] < FWIDTH_W'(MIN_DIM)) begin
         w_new = WE_W'(MIN_DIM);
      end else if (32'(pwdata[FWIDTH_W-1:0]) > MAX_WIDTH) begin
         w_new = WE_W'(MAX_WIDTH);
      end else begin
         w_new = WE_W'(pwdata[FWIDTH_W-1:0]);
      end
      h_new = (pwdata[ROW_W-1:0] < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : pwdata[ROW_W-1:0];
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      w_eff_in        = w_eff_ff;
      h_eff_in        = h_eff_ff;
      total_in        = total_ff;
      if (cfg_wr) begin
         unique case (reg_sel)
            REG_FRAME_WIDTH: begin
               frame_width_in = pwdata[FWIDTH_W-1:0];
               w_eff_in       = w_new;
               total_in       = {{ROW_W{1'b0}}, w_new} * {{WE_W{1'b0}}, h_eff_ff};
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = pwdata[ROW_W-1:0];
               h_eff_in        = h_new;
               total_in        = {{ROW_W{1'b0}}, w_eff_ff} * {{WE_W{1'b0}}, h_new};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FWIDTH_W'(FRAME_WIDTH_RST);
         frame_height_ff <= ROW_W'(FRAME_HEIGHT_RST);
         w_eff_ff        <= WE_W'(RST_WEFF);
         h_eff_ff        <= ROW_W'(FRAME_HEIGHT_RST);
         total_ff        <= TOT_W'(RST_TOTAL);
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         w_eff_ff        <= w_eff_in;
         h_eff_ff        <= h_eff_in;
         total_ff        <= total_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_ff);
         REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_ff);
         default:          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // input sequencing (acceptance edge)
   // ------------------------------------------------------------------------
   logic                   acc;
   logic                   flush;
   logic [ROW_W-1:0]       in_row_ff, in_row_in;
   logic [COL_W-1:0]       in_col_ff, in_col_in;
   logic [COUNT_W-1:0]     out_count_ff, out_count_in;
   logic [COUNT_W-1:0]     cnt_inc;
   logic [WE_W-1:0]        col_inc;
   logic                   pix_emit;
   logic                   s1_valid_ff, s1_valid_in;
   s1_ctrl_type            s1_ctrl_ff, s1_ctrl_in;
   logic [COL_W-1:0]       s1_col_ff;
   logic [PIX_W-1:0]       s1_cur_ff;
   logic [3*SAMPLE_W-1:0]  cur_px;
   logic                   ram_rd_en;
   logic [QCNT_W-1:0]      q_count;

   assign acc     = req_valid && !req_stall;
   assign flush   = in_row_ff >= h_eff_ff;
   assign cnt_inc = out_count_ff + COUNT_W'(1);
   assign col_inc = {1'b0, in_col_ff} + WE_W'(1);
   assign cur_px  = {req_sample_c, req_sample_b, req_sample_a};
   assign pix_emit = (in_row_ff >= ROW_W'(2))
                  || (in_row_ff == ROW_W'(1) && in_col_ff != '0);
   assign ram_rd_en = acc && !flush && !req_is_pad;

   // room for the item in flight plus one more before the queue could fill
   assign req_stall = ({1'b0, q_count} + (QCNT_W+1)'(s1_valid_ff))
                      >= (QCNT_W+1)'(OUT_QDEPTH);

   always_comb begin
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      out_count_in = out_count_ff;
      s1_valid_in  = 1'b0;
      s1_ctrl_in   = '0;
      if (acc) begin
         if (flush) begin
            // flush phase: border zeros until the frame count is reached
            s1_valid_in          = 1'b1;
            s1_ctrl_in.emit      = 1'b1;
            s1_ctrl_in.frame_end = cnt_inc >= COUNT_W'(total_ff);
            if (s1_ctrl_in.frame_end) begin
               in_row_in    = '0;
               in_col_in    = '0;
               out_count_in = '0;
            end else begin
               out_count_in = cnt_inc;
            end
         end else if (!req_is_pad) begin
            s1_valid_in         = 1'b1;
            s1_ctrl_in.pix      = 1'b1;
            s1_ctrl_in.emit     = pix_emit;
            s1_ctrl_in.interior = (in_row_ff >= ROW_W'(2)) && (in_col_ff >= COL_W'(2));
            if (col_inc >= w_eff_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = col_inc[COL_W-1:0];
            end
            if (pix_emit) begin
               out_count_in = cnt_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         out_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s1_ctrl_ff   <= '0;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         out_count_ff <= out_count_in;
         s1_valid_ff  <= s1_valid_in;
         s1_ctrl_ff   <= s1_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         s1_col_ff <= in_col_ff;
         s1_cur_ff <= cur_px[PIX_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // line buffers and window (stage 1)
   // ------------------------------------------------------------------------
   logic             line_wr;
   logic [PIX_W-1:0] top_rd;
   logic [PIX_W-1:0] mid_rd;
   logic [PIX_W-1:0] win_left_ff;
   logic [PIX_W-1:0] win_centre_ff;
   logic [PIX_W-1:0] win_up_ff;
   logic [PIX_W-1:0] win_down_ff;

   assign line_wr = s1_valid_ff && s1_ctrl_ff.pix;

   lsh_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_older_line (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (ram_rd_en),
      .rd_addr (in_col_ff),
      .rd_data (top_rd)
   );

   lsh_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_newer_line (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (s1_col_ff),
      .wr_data (s1_cur_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   always_ff @(posedge clock) begin
      if (line_wr) begin
         win_left_ff   <= win_centre_ff;
         win_centre_ff <= mid_rd;
         win_up_ff     <= top_rd;
         win_down_ff   <= s1_cur_ff;
      end
   end

   // ------------------------------------------------------------------------
   // kernel lanes, one per channel, merged into the result queue
   // ------------------------------------------------------------------------
   logic [PIX_W-1:0] sharp_vec;

   for (genvar i = 0; i < USED; i++) begin : g_lane
      lane_taps_type taps;

      always_comb begin
         taps.centre = win_centre_ff[SAMPLE_W*i +: SAMPLE_W];
         taps.left   = win_left_ff[SAMPLE_W*i +: SAMPLE_W];
         taps.right  = mid_rd[SAMPLE_W*i +: SAMPLE_W];
         taps.up     = win_up_ff[SAMPLE_W*i +: SAMPLE_W];
         taps.down   = win_down_ff[SAMPLE_W*i +: SAMPLE_W];
      end

      lsh_lane u_lane (
         .taps     (taps),
         .interior (s1_ctrl_ff.interior),
         .sharp    (sharp_vec[SAMPLE_W*i +: SAMPLE_W])
      );
   end

   logic          q_push;
   logic          q_pop;
   logic [QW-1:0] q_head;

   assign q_push    = s1_valid_ff && s1_ctrl_ff.emit;
   assign q_pop     = rsp_valid && !rsp_stall;
   assign rsp_valid = q_count != '0;

   lsh_outq #(
      .WIDTH (QW),
      .DEPTH (OUT_QDEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({s1_ctrl_ff.frame_end, sharp_vec}),
      .pop       (q_pop),
      .head_data (q_head),
      .count     (q_count)
   );

   assign rsp_frame_end = q_head[PIX_W];
   assign rsp_sharp_a   = q_head[SAMPLE_W-1:0];

   if (USED >= 2) begin : g_ch_b
      assign rsp_sharp_b = q_head[2*SAMPLE_W-1:SAMPLE_W];
   end else begin : g_no_ch_b
      assign rsp_sharp_b = '0;
   end

   if (USED >= 3) begin : g_ch_c
      assign rsp_sharp_c = q_head[3*SAMPLE_W-1:2*SAMPLE_W];
   end else begin : g_no_ch_c
      assign rsp_sharp_c = '0;
   end

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |-> (q_count != QCNT_W'(OUT_QDEPTH)))
      else $error("result queue overflow");

   a_line_no_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && line_wr) |-> (in_col_ff != s1_col_ff))
      else $error("line buffer read and write hit the same column");

   a_frame_end_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ctrl_ff.frame_end) |-> (out_count_ff == '0 && in_row_ff == '0))
      else $error("frame end without counter restart");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 cross-kernel sharpener. Frames of pixels and
// their flush items are queued and driven with random gaps. Each accepted item
// runs through a line-buffer model that works out the expected result. Results
// are checked field by field in order. Geometry is set over the register port
// between frames, including the clamped cases.
// ----------------------------------------------------------------------------
module tb;
   import lsh_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int QUIET_LIMIT  = 4000;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_EVERY   = 500;
   localparam int RANDOM_ITEMS = 1500;

   localparam logic [PADDR_W-1:0] ADDR_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
   localparam logic [PADDR_W-1:0] ADDR_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

   // pixel content of a queued frame
   localparam int FILL_RANDOM = 0;
   localparam int FILL_PEAK   = 1;   // bright centre on black
   localparam int FILL_PIT    = 2;   // black centre on white

   typedef struct packed {
      logic                is_pad;
      logic [SAMPLE_W-1:0] sample_c;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_a;
   } pixel_type;

   typedef struct packed {
      logic                frame_end;
      logic [SAMPLE_W-1:0] sharp_c;
      logic [SAMPLE_W-1:0] sharp_b;
      logic [SAMPLE_W-1:0] sharp_a;
   } sharp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_a = '0;
   logic [SAMPLE_W-1:0] req_sample_b = '0;
   logic [SAMPLE_W-1:0] req_sample_c = '0;
   logic                req_is_pad = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_sharp_a;
   logic [SAMPLE_W-1:0] rsp_sharp_b;
   logic [SAMPLE_W-1:0] rsp_sharp_c;
   logic                rsp_frame_end;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [PADDR_W-1:0]  paddr = '0;
   logic [PDATA_W-1:0]  pwdata = '0;
   logic [PDATA_W-1:0]  prdata;
   logic                pready;

   laplacian_sharpen_3x3 uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_a  (req_sample_a),
      .req_sample_b  (req_sample_b),
      .req_sample_c  (req_sample_c),
      .req_is_pad    (req_is_pad),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sharp_a   (rsp_sharp_a),
      .rsp_sharp_b   (rsp_sharp_b),
      .rsp_sharp_c   (rsp_sharp_c),
      .rsp_frame_end (rsp_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #CLK_HALF clock = ~clock;

   pixel_type pixel_backlog[$];
   sharp_type sharp_expected[$];
   int        err_count = 0;
   bit        no_idle = 1'b0;

   // ---------------------------------------------------------------------
   // Filter model: geometry registers, line stores, window, counters
   // ---------------------------------------------------------------------
   logic [FWIDTH_W-1:0] cfg_width  = FWIDTH_W'(FRAME_WIDTH_RST);
   logic [ROW_W-1:0]    cfg_height = ROW_W'(FRAME_HEIGHT_RST);
   logic [23:0]         line_older [LSH_MAX_WIDTH];
   logic [23:0]         line_newer [LSH_MAX_WIDTH];
   logic [23:0]         win [6];
   int unsigned         row_in = 0;
   int unsigned         col_in = 0;
   int unsigned         out_seen = 0;

   initial begin
      for (int i = 0; i < LSH_MAX_WIDTH; i++) begin
         line_older[i] = '0;
         line_newer[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
   end

   function automatic bit sharpen_predict(input pixel_type px, output sharp_type res);
      int unsigned w, h, total, col;
      logic [23:0] cur, top, mid, acc;
      logic [23:0] cc, ll, rr, uu, dd;
      bit interior, emits;
      int v;
      w = 32'(cfg_width);
      if (w < MIN_DIM) w = MIN_DIM;
      if (w > LSH_MAX_WIDTH) w = LSH_MAX_WIDTH;
      h = (cfg_height < MIN_DIM) ? MIN_DIM : 32'(cfg_height);
      total = w * h;
      res = '0;
      // all rows in: every further item flushes out a border result
      if (row_in >= h) begin
         out_seen++;
         if (out_seen >= total) begin
            res.frame_end = 1'b1;
            row_in = 0;
            col_in = 0;
            out_seen = 0;
         end
         return 1'b1;
      end
      if (px.is_pad) return 1'b0;
      col = col_in & (LSH_MAX_WIDTH - 1);
      cur = {px.sample_c, px.sample_b, px.sample_a};
      top = line_older[col];
      mid = line_newer[col];
      interior = row_in >= 2 && col >= 2;
      acc = '0;
      if (interior) begin
         cc = win[4]; ll = win[1]; rr = mid; uu = win[3]; dd = win[5];
         for (int ch = 0; ch < 3; ch++) begin
            v = SHARP_GAIN * int'(cc[8*ch +: 8]) - int'(ll[8*ch +: 8])
              - int'(rr[8*ch +: 8]) - int'(uu[8*ch +: 8]) - int'(dd[8*ch +: 8]);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            acc[8*ch +: 8] = v[7:0];
         end
      end
      emits = row_in >= 2 || (row_in == 1 && col >= 1);
      line_older[col] = mid;
      line_newer[col] = cur;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = cur;
      if (col + 1 >= w) begin
         col_in = 0;
         row_in = (row_in + 1) & 32'hFFFF;
      end else begin
         col_in = col + 1;
      end
      if (!emits) return 1'b0;
      out_seen++;
      res.sharp_a = acc[7:0];
      res.sharp_b = acc[15:8];
      res.sharp_c = acc[23:16];
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Pixel driver
   // ---------------------------------------------------------------------
   pixel_type   on_wire = '0;
   sharp_type   predicted;
   int unsigned tx_gap = 0;
   int unsigned tx_mode_left = 0;
   int unsigned tx_pct = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (tx_mode_left == 0) begin
            tx_mode_left = $urandom_range(400, 100);
            case ($urandom_range(2))
               0: tx_pct = 0;
               1: tx_pct = 10;
               default: tx_pct = 40;
            endcase
         end else begin
            tx_mode_left--;
         end
         if (req_valid && !req_stall) begin
            if (sharpen_predict(on_wire, predicted)) sharp_expected.push_back(predicted);
         end
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() > 0 && !no_idle &&
                         $urandom_range(99) < tx_pct) begin
               tx_gap = $urandom_range(8);
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() > 0) begin
               on_wire = pixel_backlog.pop_front();
               req_sample_a <= on_wire.sample_a;
               req_sample_b <= on_wire.sample_b;
               req_sample_c <= on_wire.sample_c;
               req_is_pad   <= on_wire.is_pad;
               req_valid    <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor and receiver stalls
   // ---------------------------------------------------------------------
   sharp_type   want;
   int unsigned results_seen = 0;
   int unsigned rx_hold = 0;
   int unsigned rx_burst = 0;
   int unsigned rx_mode_left = 0;
   int unsigned rx_pct = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            // long hold-off so the result queue fills and the input backs up
            if (!no_idle && results_seen % HOLD_EVERY == 0) rx_hold = LONG_HOLD;
            if (sharp_expected.size() == 0) begin
               $error("result transfer with nothing expected");
               err_count++;
            end else begin
               want = sharp_expected.pop_front();
               if (rsp_sharp_a !== want.sharp_a) begin
                  $error("sharp_a: expected %0d, got %0d", want.sharp_a, rsp_sharp_a);
                  err_count++;
               end
               if (rsp_sharp_b !== want.sharp_b) begin
                  $error("sharp_b: expected %0d, got %0d", want.sharp_b, rsp_sharp_b);
                  err_count++;
               end
               if (rsp_sharp_c !== want.sharp_c) begin
                  $error("sharp_c: expected %0d, got %0d", want.sharp_c, rsp_sharp_c);
                  err_count++;
               end
               if (rsp_frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_frame_end);
                  err_count++;
               end
            end
         end
         if (rx_mode_left == 0) begin
            rx_mode_left = $urandom_range(400, 100);
            case ($urandom_range(2))
               0: rx_pct = 0;
               1: rx_pct = 10;
               default: rx_pct = 40;
            endcase
         end else begin
            rx_mode_left--;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_burst > 0) begin
            rx_burst--;
            rsp_stall <= 1'b1;
         end else if (!no_idle && $urandom_range(99) < rx_pct) begin
            rx_burst = $urandom_range(8);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: cycles without any transfer
   // ---------------------------------------------------------------------
   int unsigned quiet = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return SAMPLE_W'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_type junk_item(logic pad);
      pixel_type it;
      it.is_pad   = pad;
      it.sample_a = SAMPLE_W'($urandom);
      it.sample_b = SAMPLE_W'($urandom);
      it.sample_c = SAMPLE_W'($urandom);
      return it;
   endfunction

   // Queues rows*w pixels then flush items; returns the items that count.
   // Noisy frames carry pads mid-frame (dropped) and data items in the flush.
   function automatic int queue_frame(int unsigned w, int unsigned rows,
                                      int unsigned flush, bit noisy, int fill);
      pixel_type it;
      int n;
      n = 0;
      for (int unsigned r = 0; r < rows; r++) begin
         for (int unsigned c = 0; c < w; c++) begin
            if (noisy && ((r == 1 && c == 0) || $urandom_range(24) == 0))
               pixel_backlog.push_back(junk_item(1'b1));
            it.is_pad = 1'b0;
            case (fill)
               FILL_PEAK: begin
                  it.sample_a = (r == 1 && c == 1) ? '1 : '0;
                  it.sample_b = it.sample_a;
                  it.sample_c = it.sample_a;
               end
               FILL_PIT: begin
                  it.sample_a = (r == 1 && c == 1) ? '0 : '1;
                  it.sample_b = it.sample_a;
                  it.sample_c = it.sample_a;
               end
               default: begin
                  it.sample_a = pick_sample();
                  it.sample_b = pick_sample();
                  it.sample_c = pick_sample();
               end
            endcase
            pixel_backlog.push_back(it);
            n++;
         end
      end
      for (int unsigned i = 0; i < flush; i++) begin
         // pixel data past the last row counts as a flush item
         pixel_backlog.push_back(junk_item(!(noisy && (i == 0 || $urandom_range(2) == 0))));
         n++;
      end
      return n;
   endfunction

   task automatic wait_drained();
      do @(negedge clock);
      while (pixel_backlog.size() != 0 || req_valid || sharp_expected.size() != 0);
      // dropped pads may still be in the pipeline
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_WIDTH) cfg_width = data[FWIDTH_W-1:0];
      else if (addr == ADDR_HEIGHT) cfg_height = data[ROW_W-1:0];
   endtask

   task automatic csr_check(input logic [PADDR_W-1:0] addr, input string name,
                            input logic [PDATA_W-1:0] wanted);
      logic [PDATA_W-1:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== wanted) begin
         $error("%s: expected %0d, got %0d", name, wanted, got);
         err_count++;
      end
   endtask

   task automatic set_geometry(input logic [PDATA_W-1:0] wval, input logic [PDATA_W-1:0] hval);
      wait_drained();
      csr_write(ADDR_WIDTH, wval);
      csr_write(ADDR_HEIGHT, hval);
      csr_check(ADDR_WIDTH, "frame_width", PDATA_W'(wval[FWIDTH_W-1:0]));
      csr_check(ADDR_HEIGHT, "frame_height", PDATA_W'(hval[ROW_W-1:0]));
      @(negedge clock);
   endtask

   initial begin
      int unsigned w, h, cur_w;
      int n_items;
      logic [PDATA_W-1:0] wval, hval;
      bit first;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      csr_check(ADDR_WIDTH, "frame_width", FRAME_WIDTH_RST);
      csr_check(ADDR_HEIGHT, "frame_height", FRAME_HEIGHT_RST);

      // undersized registers clamp to 3x3; saturation at both ends
      set_geometry(32'd0, 32'd1);
      void'(queue_frame(3, 3, 4, 1'b1, FILL_PEAK));
      void'(queue_frame(3, 3, 4, 1'b1, FILL_PIT));

      // tallest frame, cut short by lowering the height once six rows are in
      set_geometry(32'd4, 32'hFFFF);
      void'(queue_frame(4, 6, 0, 1'b0, FILL_RANDOM));
      set_geometry(32'd4, 32'h5A5A_0006);
      void'(queue_frame(4, 0, 5, 1'b0, FILL_RANDOM));

      n_items = 0;
      first = 1'b1;
      cur_w = 4;
      while (n_items < RANDOM_ITEMS) begin
         if (first || $urandom_range(2) == 0) begin
            case ($urandom_range(9))
               0, 1:    w = 3;
               2:       w = $urandom_range(40, 11);
               default: w = $urandom_range(10, 4);
            endcase
            h = ($urandom_range(3) == 0) ? 3 : $urandom_range(7, 4);
            wval = w;
            hval = h;
            if (w == 3 && $urandom_range(1)) wval = $urandom_range(2);
            if (h == 3 && $urandom_range(1)) hval = $urandom_range(2);
            if ($urandom_range(3) == 0) begin
               wval[PDATA_W-1:FWIDTH_W] = (PDATA_W-FWIDTH_W)'($urandom);
               hval[PDATA_W-1:ROW_W]    = (PDATA_W-ROW_W)'($urandom);
            end
            set_geometry(wval, hval);
            cur_w = w;
            first = 1'b0;
         end else begin
            h = (cfg_height < MIN_DIM) ? MIN_DIM : 32'(cfg_height);
         end
         @(negedge clock);
         if (n_items > RANDOM_ITEMS - 300) no_idle = 1'b1;
         n_items += queue_frame(cur_w, h, cur_w + 1, 1'($urandom_range(1)), FILL_RANDOM);
         if ($urandom_range(4) == 0) pixel_backlog.push_back(junk_item(1'b1));
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== laplacian_sharpen_3x3.f =====
rtl/lsh_pkg.sv
rtl/lsh_ram.sv
rtl/lsh_lane.sv
rtl/lsh_outq.sv
rtl/laplacian_sharpen_3x3.sv
tb/tb.sv
